### hw/rtl/bpc_pkg.sv
`timescale 1ns / 1ps
package bpc_pkg;

    // Status codes
    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_ADC  = 2'd1;
    localparam logic [1:0] ST_DIV  = 2'd2;
    localparam logic [1:0] ST_NEG  = 2'd3;

    // Register indexes
    localparam logic [2:0] REG_T1     = 3'd0;
    localparam logic [2:0] REG_T2     = 3'd1;
    localparam logic [2:0] REG_T3     = 3'd2;
    localparam logic [2:0] REG_P1     = 3'd3;
    localparam logic [2:0] REG_P_LOW  = 3'd4;
    localparam logic [2:0] REG_P_HIGH = 3'd5;

    localparam int MUL_STAGES = 13;
    localparam int DIV_CELLS  = 64;

    localparam logic [63:0] TF_OFFSET  = 64'd128000;
    localparam logic [63:0] FULL_SCALE = 64'd1048576;
    localparam logic [63:0] NUM_SCALE  = 64'd3125;
    localparam logic [17:0] PA_MAX     = 18'h3FFFF;

    // Sideband that rides alongside each multiplier stage
    typedef struct packed {
        logic        vld;
        logic [1:0]  st;
        logic [19:0] adc_p;
        logic [63:0] a;
        logic [63:0] b;
        logic [63:0] c;
    } ctx_t;

    // State handed from one divider cell to the next
    typedef struct packed {
        logic        vld;
        logic [1:0]  st;
        logic        neg;
        logic [63:0] rem;
        logic [63:0] nq;
        logic [63:0] den;
    } div_t;

endpackage

### hw/rtl/bpc_mul_stage.sv
`timescale 1ns / 1ps
module bpc_mul_stage
    import bpc_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        en,
    input  ctx_t        ctx_in,
    input  logic [63:0] op_a,
    input  logic [63:0] op_b,
    output ctx_t        ctx_out,
    output logic [63:0] prod
);

    logic [63:0] ll_reg;
    logic [31:0] lh_reg, hl_reg;
    ctx_t        ctx1_reg, ctx2_reg;
    logic [63:0] prod_reg;
    logic [63:0] ll_next;
    logic [63:0] lh_full, hl_full;
    logic [63:0] prod_next;

    // Form the partial products of the low 64 bits
    always_comb begin
        ll_next   = op_a[31:0] * op_b[31:0];
        lh_full   = op_a[31:0] * op_b[63:32];
        hl_full   = op_a[63:32] * op_b[31:0];
        prod_next = ll_reg + {lh_reg + hl_reg, 32'd0};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ctx1_reg.vld <= 1'b0;
            ctx2_reg.vld <= 1'b0;
        end else if (en) begin
            ctx1_reg <= ctx_in;
            ll_reg   <= ll_next;
            lh_reg   <= lh_full[31:0];
            hl_reg   <= hl_full[31:0];
            ctx2_reg <= ctx1_reg;
            prod_reg <= prod_next;
        end
    end

    assign ctx_out = ctx2_reg;
    assign prod    = prod_reg;

endmodule

### hw/rtl/bpc_div_cell.sv
`timescale 1ns / 1ps
module bpc_div_cell
    import bpc_pkg::*;
(
    input  logic aclk,
    input  logic aresetn,
    input  logic en,
    input  div_t d_in,
    output div_t d_out
);

    div_t        d_reg, d_next;
    logic [64:0] shifted, diff;

    // One restoring step: shift in a dividend bit, subtract when it fits
    always_comb begin
        shifted = {d_in.rem, d_in.nq[63]};
        diff    = shifted - {1'b0, d_in.den};
        d_next  = d_in;
        if (!diff[64]) begin
            d_next.rem = diff[63:0];
            d_next.nq  = {d_in.nq[62:0], 1'b1};
        end else begin
            d_next.rem = shifted[63:0];
            d_next.nq  = {d_in.nq[62:0], 1'b0};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            d_reg.vld <= 1'b0;
        end else if (en) begin
            d_reg <= d_next;
        end
    end

    assign d_out = d_reg;

endmodule

### hw/rtl/bpc_divider.sv
`timescale 1ns / 1ps
module bpc_divider
    import bpc_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        en,
    input  logic        vld_in,
    input  logic [1:0]  st_in,
    input  logic [63:0] num,
    input  logic [63:0] den,
    output logic        vld_out,
    output logic [1:0]  st_out,
    output logic [63:0] quo
);

    div_t chain [DIV_CELLS+1];

    // Take magnitudes at the head of the chain
    always_comb begin
        chain[0].vld = vld_in;
        chain[0].st  = st_in;
        chain[0].neg = num[63] ^ den[63];
        chain[0].rem = '0;
        chain[0].nq  = num[63] ? (64'd0 - num) : num;
        chain[0].den = den[63] ? (64'd0 - den) : den;
    end

    for (genvar i = 0; i < DIV_CELLS; i++) begin : g_cell
        bpc_div_cell u_cell (
            .aclk    (aclk),
            .aresetn (aresetn),
            .en      (en),
            .d_in    (chain[i]),
            .d_out   (chain[i+1])
        );
    end

    // Restore the sign of the quotient
    assign vld_out = chain[DIV_CELLS].vld;
    assign st_out  = chain[DIV_CELLS].st;
    assign quo     = chain[DIV_CELLS].neg ? (64'd0 - chain[DIV_CELLS].nq)
                                          : chain[DIV_CELLS].nq;

endmodule

### hw/rtl/baro_pressure_comp_64.sv
`timescale 1ns / 1ps
// Path from an accepted input word to its result word: 13 multiplier
// stages, 64 divider cells and one output register.
// Throughput: one word per cycle; the whole pipeline holds only while a
// result waits untaken in the output register.
// Reset: synchronous, active low; clears all valid flags and the
// calibration registers to zero.
module baro_pressure_comp_64
    import bpc_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // raw_pressure[19:0], raw_temperature[39:20]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // pressure[17:0], status[19:18], zero[23:20]
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [63:0] cfg_data
);

    logic [15:0] t1_reg, t2_reg, t3_reg, p1_reg;
    logic [63:0] plo_reg, phi_reg;
    logic        en;

    ctx_t        ci [MUL_STAGES];
    ctx_t        co [MUL_STAGES];
    logic [63:0] ma [MUL_STAGES];
    logic [63:0] mb [MUL_STAGES];
    logic [63:0] pr [MUL_STAGES];

    logic        dv_vld;
    logic [1:0]  dv_st;
    logic [63:0] dv_quo;

    logic        m_tvalid_reg, m_tvalid_next;
    logic [17:0] pa_reg, pa_next;
    logic [1:0]  st_reg, st_next;

    logic [19:0] adc_p, adc_t;
    logic [31:0] d1, d2, q12, a1, a2, tf;
    logic [63:0] v1, v2, v1b, dvs, pp, tnum, sq, sum, pf;
    logic [63:0] p2, p3, p4, p5, p6, p7, p8, p9;

    assign adc_p = s_tdata[19:0];
    assign adc_t = s_tdata[39:20];
    assign p2 = {{48{plo_reg[15]}}, plo_reg[15:0]};
    assign p3 = {{48{plo_reg[31]}}, plo_reg[31:16]};
    assign p4 = {{48{plo_reg[47]}}, plo_reg[47:32]};
    assign p5 = {{48{plo_reg[63]}}, plo_reg[63:48]};
    assign p6 = {{48{phi_reg[15]}}, phi_reg[15:0]};
    assign p7 = {{48{phi_reg[31]}}, phi_reg[31:16]};
    assign p8 = {{48{phi_reg[47]}}, phi_reg[47:32]};
    assign p9 = {{48{phi_reg[63]}}, phi_reg[63:48]};

    // Hold the pipeline only while a result waits untaken
    assign en        = !m_tvalid_reg || m_tready;
    assign s_tready  = en;
    assign cfg_ready = 1'b1;

    // Calibration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            t1_reg  <= '0;
            t2_reg  <= '0;
            t3_reg  <= '0;
            p1_reg  <= '0;
            plo_reg <= '0;
            phi_reg <= '0;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                REG_T1:     t1_reg  <= cfg_data[15:0];
                REG_T2:     t2_reg  <= cfg_data[15:0];
                REG_T3:     t3_reg  <= cfg_data[15:0];
                REG_P1:     p1_reg  <= cfg_data[15:0];
                REG_P_LOW:  plo_reg <= cfg_data;
                REG_P_HIGH: phi_reg <= cfg_data;
                default:    ;
            endcase
        end
    end

    for (genvar k = 0; k < MUL_STAGES; k++) begin : g_mul
        bpc_mul_stage u_mul (
            .aclk    (aclk),
            .aresetn (aresetn),
            .en      (en),
            .ctx_in  (ci[k]),
            .op_a    (ma[k]),
            .op_b    (mb[k]),
            .ctx_out (co[k]),
            .prod    (pr[k])
        );
    end

    bpc_divider u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .en      (en),
        .vld_in  (co[9].vld),
        .st_in   (co[9].st),
        .num     (pr[9]),
        .den     (co[9].a),
        .vld_out (dv_vld),
        .st_out  (dv_st),
        .quo     (dv_quo)
    );

    // Glue between multiplier stages
    always_comb begin
        // temperature differences, first product d1 * T2
        d1 = {15'd0, adc_t[19:3]} - {15'd0, t1_reg, 1'b0};
        d2 = {16'd0, adc_t[19:4]} - {16'd0, t1_reg};
        ci[0]       = '0;
        ci[0].vld   = s_tvalid;
        ci[0].adc_p = adc_p;
        ci[0].st    = (adc_p == '0 || adc_t == '0) ? ST_ADC : ST_OK;
        ci[0].a     = {32'd0, d2};
        ma[0] = {32'd0, d1};
        mb[0] = {{48{t2_reg[15]}}, t2_reg};

        // d2 squared
        a1 = 32'($signed(pr[0][31:0]) >>> 11);
        ci[1]   = co[0];
        ci[1].a = {32'd0, a1};
        ma[1] = co[0].a;
        mb[1] = co[0].a;

        // times T3
        q12 = 32'($signed(pr[1][31:0]) >>> 12);
        ci[2] = co[1];
        ma[2] = {32'd0, q12};
        mb[2] = {{48{t3_reg[15]}}, t3_reg};

        // fine temperature and v1 squared
        a2 = 32'($signed(pr[2][31:0]) >>> 14);
        tf = co[2].a[31:0] + a2;
        v1 = {{32{tf[31]}}, tf} - TF_OFFSET;
        ci[3]   = co[2];
        ci[3].a = v1;
        ma[3] = v1;
        mb[3] = v1;

        // v1^2 * P6
        ci[4]   = co[3];
        ci[4].b = pr[3];
        ma[4] = pr[3];
        mb[4] = p6;

        // v1 * P5
        ci[5]   = co[4];
        ci[5].c = pr[4];
        ma[5] = co[4].a;
        mb[5] = p5;

        // v1^2 * P3
        v2 = co[5].c + (pr[5] << 17) + (p4 << 35);
        ci[6]   = co[5];
        ci[6].c = v2;
        ma[6] = co[5].b;
        mb[6] = p3;

        // v1 * P2
        ci[7]   = co[6];
        ci[7].b = 64'($signed(pr[6]) >>> 8);
        ma[7] = co[6].a;
        mb[7] = p2;

        // divisor term times P1
        v1b = co[7].b + (pr[7] << 12);
        ci[8] = co[7];
        ma[8] = (64'd1 << 47) + v1b;
        mb[8] = {48'd0, p1_reg};

        // numerator times 3125
        dvs  = 64'($signed(pr[8]) >>> 33);
        pp   = FULL_SCALE - {44'd0, co[8].adc_p};
        tnum = (pp << 31) - co[8].c;
        ci[9]   = co[8];
        ci[9].a = dvs;
        if (co[8].st == ST_OK && dvs == '0) begin
            ci[9].st = ST_DIV;
        end
        ma[9] = tnum;
        mb[9] = NUM_SCALE;

        // P9 * (p >> 13)
        sq = 64'($signed(dv_quo) >>> 13);
        ci[10]     = '0;
        ci[10].vld = dv_vld;
        ci[10].st  = dv_st;
        ci[10].a   = dv_quo;
        ci[10].b   = sq;
        ma[10] = p9;
        mb[10] = sq;

        // times (p >> 13) again
        ci[11] = co[10];
        ma[11] = pr[10];
        mb[11] = co[10].b;

        // P8 * p
        ci[12]   = co[11];
        ci[12].b = 64'($signed(pr[11]) >>> 25);
        ma[12] = p8;
        mb[12] = co[11].a;

        // final sum, sign check and saturation
        sum = co[12].a + co[12].b + 64'($signed(pr[12]) >>> 19);
        pf  = 64'($signed(sum) >>> 8) + (p7 << 4);
        m_tvalid_next = co[12].vld;
        st_next       = co[12].st;
        if (st_next == ST_OK && pf[63]) begin
            st_next = ST_NEG;
        end
        if (st_next != ST_OK) begin
            pa_next = '0;
        end else if (|pf[63:26]) begin
            pa_next = PA_MAX;
        end else begin
            pa_next = pf[25:8];
        end
    end

    // Output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (en) begin
            m_tvalid_reg <= m_tvalid_next;
            pa_reg       <= pa_next;
            st_reg       <= st_next;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {4'd0, st_reg, pa_reg};

endmodule
